// ===== src/separable_gaussian_blur_top_macros.svh =====
// Assertion macros used by the blur sequencer (sgb_ctrl).
// Needs clk_i and rst_ni in the scope of every use.
`ifndef SEPARABLE_GAUSSIAN_BLUR_TOP_MACROS_SVH
`define SEPARABLE_GAUSSIAN_BLUR_TOP_MACROS_SVH

// Condition must never hold out of reset.
`define SGB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// Same-cycle implication.
`define SGB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sgb_pkg.sv =====
// Shared types and constants of the separable blur.
// No dependencies.
package sgb_pkg;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_BLUR  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [2:0] REG_RADIUS       = 3'd0;
  localparam logic [2:0] REG_COEF_CENTER  = 3'd1;
  localparam logic [2:0] REG_COEF_ONE     = 3'd2;
  localparam logic [2:0] REG_COEF_TWO     = 3'd3;
  localparam logic [2:0] REG_COEF_THREE   = 3'd4;
  localparam logic [2:0] REG_COEF_FOUR    = 3'd5;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd6;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd7;

  // weight select codes
  localparam logic [2:0] WSEL_CENTER = 3'd0;
  localparam logic [2:0] WSEL_ONE    = 3'd1;
  localparam logic [2:0] WSEL_TWO    = 3'd2;
  localparam logic [2:0] WSEL_THREE  = 3'd3;
  localparam logic [2:0] WSEL_FOUR   = 3'd4;
  localparam logic [2:0] WSEL_NONE   = 3'd5;

  localparam int unsigned ACC_W = 28;
  localparam logic [ACC_W-1:0] ROUND_HALF = 28'd32768;

  typedef struct packed {
    logic [15:0] center;
    logic [15:0] one;
    logic [15:0] two;
    logic [15:0] three;
    logic [15:0] four;
  } sgb_coef_t;

  typedef struct packed {
    logic       tap_en;
    logic       tap_first;
    logic [2:0] wsel;
    logic       fin_en;
    logic       lb_rd;
    logic       px_wr;
    logic       px_rd;
    logic       px_done;
    logic       px_err;
    logic       blur_done;
  } sgb_cmd_t;

  // round to nearest, saturate to 8 bits
  function automatic logic [7:0] round_sat(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] s;
    s = acc + ROUND_HALF;
    if (|s[ACC_W-1:24]) return 8'hFF;
    return s[23:16];
  endfunction

endpackage

// ===== src/separable_gaussian_blur_top.sv =====
// Separable Gaussian blur over an RGBA8 frame store, top level.
// Depends on sgb_pkg, sgb_ctrl and sgb_datapath.
//
// Commands go in on start_i while busy_o is low; each gives exactly one
// result, shown for one cycle with done_o high, and the receiver cannot
// stall it. Pixel writes and reads may follow back to back; a read's data
// and status appear in the cycle after the transfer. A blur keeps busy_o
// high while it walks the frame through one frame-store read port, one tap
// per cycle within each output pixel: for each pixel the taps across the
// clamped radius are read, the MAC pipeline drains and the result goes into
// the line buffer, and each finished line is then written back to the frame
// store; the row pass runs first, then the column pass. Pixels never written
// hold no defined value. Configuration writes are always accepted (cfg_ready_o
// is tied high) and must only be made while the block is idle.
module separable_gaussian_blur_top #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_RADIUS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [5:0]  col_i,
  input  logic [5:0]  row_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  alpha_in_i,
  output logic        done_o,
  output logic        status_o,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic [7:0]  alpha_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import sgb_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int LD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int PW  = $clog2(LD + 1);
  localparam int LIW = $clog2(LD);
  localparam int RDW = $clog2(MAX_RADIUS + 1);

  // configuration registers
  logic [2:0]  radius_q;
  sgb_coef_t   coef_q;
  logic [6:0]  frame_width_q, frame_height_q;

  logic        cfg_we;
  logic [PW-1:0]  w_eff, h_eff;
  logic [RDW-1:0] r_eff;

  sgb_cmd_t          cmd;
  logic [RW+CW-1:0]  st_addr, wb_addr;
  logic [LIW-1:0]    lb_addr;
  logic [31:0]       px_out;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q       <= 3'd1;
      coef_q.center  <= 16'd32768;
      coef_q.one     <= 16'd16384;
      coef_q.two     <= 16'd0;
      coef_q.three   <= 16'd0;
      coef_q.four    <= 16'd0;
      frame_width_q  <= 7'd64;
      frame_height_q <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_RADIUS:       radius_q       <= cfg_data_i[2:0];
        REG_COEF_CENTER:  coef_q.center  <= cfg_data_i;
        REG_COEF_ONE:     coef_q.one     <= cfg_data_i;
        REG_COEF_TWO:     coef_q.two     <= cfg_data_i;
        REG_COEF_THREE:   coef_q.three   <= cfg_data_i;
        REG_COEF_FOUR:    coef_q.four    <= cfg_data_i;
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[6:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, above the store as its max; radius clamped
  always_comb begin
    if (frame_width_q == '0)                      w_eff = PW'(1);
    else if (13'(frame_width_q) > 13'(MAX_WIDTH)) w_eff = PW'(MAX_WIDTH);
    else                                          w_eff = PW'(frame_width_q);
    if (frame_height_q == '0)                       h_eff = PW'(1);
    else if (13'(frame_height_q) > 13'(MAX_HEIGHT)) h_eff = PW'(MAX_HEIGHT);
    else                                            h_eff = PW'(frame_height_q);
    if (5'(radius_q) > 5'(MAX_RADIUS)) r_eff = RDW'(MAX_RADIUS);
    else                               r_eff = RDW'(radius_q);
  end

  sgb_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .action_i  (action_i),
    .col_i     (col_i),
    .row_i     (row_i),
    .w_eff_i   (w_eff),
    .h_eff_i   (h_eff),
    .r_eff_i   (r_eff),
    .busy_o    (busy_o),
    .cmd_o     (cmd),
    .st_addr_o (st_addr),
    .wb_addr_o (wb_addr),
    .lb_addr_o (lb_addr)
  );

  sgb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .coef_i    (coef_q),
    .st_addr_i (st_addr),
    .wb_addr_i (wb_addr),
    .lb_addr_i (lb_addr),
    .px_data_i ({alpha_in_i, blue_in_i, green_in_i, red_in_i}),
    .done_o    (done_o),
    .status_o  (status_o),
    .px_out_o  (px_out)
  );

  assign red_out_o   = px_out[7:0];
  assign green_out_o = px_out[15:8];
  assign blue_out_o  = px_out[23:16];
  assign alpha_out_o = px_out[31:24];

endmodule

// ===== src/sgb_ctrl.sv =====
// Blur sequencer: pixel command decode and the row/column pass walk.
// Depends on sgb_pkg and the assertion macro header.
`include "separable_gaussian_blur_top_macros.svh"

module sgb_ctrl #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_RADIUS = 4,
  parameter int CW  = $clog2(MAX_WIDTH),
  parameter int RW  = $clog2(MAX_HEIGHT),
  parameter int PW  = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1),
  parameter int TW  = $clog2(2 * MAX_RADIUS + 1),
  parameter int RDW = $clog2(MAX_RADIUS + 1),
  parameter int LIW = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         action_i,
  input  logic [5:0]         col_i,
  input  logic [5:0]         row_i,
  input  logic [PW-1:0]      w_eff_i,
  input  logic [PW-1:0]      h_eff_i,
  input  logic [RDW-1:0]     r_eff_i,
  output logic               busy_o,
  output sgb_pkg::sgb_cmd_t  cmd_o,
  output logic [RW+CW-1:0]   st_addr_o,
  output logic [RW+CW-1:0]   wb_addr_o,
  output logic [LIW-1:0]     lb_addr_o
);
  import sgb_pkg::*;

  localparam int IW = PW + TW + 2;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TAP   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;
  localparam logic [2:0] ST_WB    = 3'd4;
  localparam logic [2:0] ST_WBEND = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic          pass_q, pass_d;
  logic [PW-1:0] line_q, line_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [TW-1:0] tap_q, tap_d;
  logic          drain_q, drain_d;

  logic [PW-1:0] len, nlines, tp;
  logic [IW-1:0] ipos;
  logic [TW-1:0] tap_dist, last_tap;
  logic          accept, in_range;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign busy_o   = (state_q != ST_IDLE);
  assign len      = pass_q ? h_eff_i : w_eff_i;
  assign nlines   = pass_q ? w_eff_i : h_eff_i;
  assign last_tap = TW'({r_eff_i, 1'b0});
  assign in_range = (13'(col_i) < 13'(w_eff_i)) && (13'(row_i) < 13'(h_eff_i));

  // clamped sample position of the current tap
  always_comb begin
    ipos = IW'(pos_q) + IW'(tap_q) - IW'(r_eff_i);
    if (ipos[IW-1])              tp = '0;
    else if (ipos >= IW'(len))   tp = len - PW'(1);
    else                         tp = ipos[PW-1:0];
    tap_dist = (tap_q >= TW'(r_eff_i)) ? (tap_q - TW'(r_eff_i))
                                       : (TW'(r_eff_i) - tap_q);
  end

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    line_d  = line_q;
    pos_d   = pos_q;
    tap_d   = tap_q;
    drain_d = drain_q;
    cmd_o   = '0;
    cmd_o.wsel = (32'(tap_dist) > 32'd4) ? WSEL_NONE : 3'(tap_dist);
    lb_addr_o = LIW'(pos_q);
    wb_addr_o = pass_q ? {RW'(pos_q), CW'(line_q)} : {RW'(line_q), CW'(pos_q)};
    if (state_q == ST_IDLE) st_addr_o = {RW'(row_i), CW'(col_i)};
    else st_addr_o = pass_q ? {RW'(tp), CW'(line_q)} : {RW'(line_q), CW'(tp)};

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (action_i == ACT_BLUR) begin
            state_d = ST_TAP;
            pass_d  = 1'b0;
            line_d  = '0;
            pos_d   = '0;
            tap_d   = '0;
          end else begin
            cmd_o.px_done = 1'b1;
            if (action_i == ACT_WRITE || action_i == ACT_READ) begin
              cmd_o.px_err = !in_range;
              cmd_o.px_wr  = (action_i == ACT_WRITE) && in_range;
              cmd_o.px_rd  = (action_i == ACT_READ) && in_range;
            end
          end
        end
      end
      ST_TAP: begin
        cmd_o.tap_en    = 1'b1;
        cmd_o.tap_first = (tap_q == '0);
        if (tap_q == last_tap) begin
          state_d = ST_DRAIN;
          drain_d = 1'b0;
        end else begin
          tap_d = tap_q + TW'(1);
        end
      end
      ST_DRAIN: begin
        drain_d = 1'b1;
        if (drain_q) state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.fin_en = 1'b1;
        tap_d = '0;
        if (pos_q == len - PW'(1)) begin
          pos_d   = '0;
          state_d = ST_WB;
        end else begin
          pos_d   = pos_q + PW'(1);
          state_d = ST_TAP;
        end
      end
      ST_WB: begin
        cmd_o.lb_rd = 1'b1;
        if (pos_q == len - PW'(1)) state_d = ST_WBEND;
        else pos_d = pos_q + PW'(1);
      end
      ST_WBEND: begin
        // last write-back lands this cycle
        pos_d = '0;
        tap_d = '0;
        if (line_q == nlines - PW'(1)) begin
          line_d = '0;
          if (pass_q) begin
            state_d = ST_DONE;
          end else begin
            pass_d  = 1'b1;
            state_d = ST_TAP;
          end
        end else begin
          line_d  = line_q + PW'(1);
          state_d = ST_TAP;
        end
      end
      ST_DONE: begin
        cmd_o.blur_done = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= 1'b0;
      line_q  <= '0;
      pos_q   <= '0;
      tap_q   <= '0;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      line_q  <= line_d;
      pos_q   <= pos_d;
      tap_q   <= tap_d;
      drain_q <= drain_d;
    end
  end

  `SGB_ASSERT_NEVER(a_one_cmd, !$onehot0({cmd_o.tap_en, cmd_o.fin_en, cmd_o.lb_rd, cmd_o.px_wr, cmd_o.px_rd}), "more than one datapath command")
  `SGB_ASSERT_NEXT(a_blur_busy, accept && action_i == ACT_BLUR, busy_o, "blur accepted but not busy")
  `SGB_ASSERT_NEXT(a_done_idle, state_q == ST_DONE, state_q == ST_IDLE, "no return to idle after blur")
  `SGB_ASSERT_IMPL(a_pos_range, busy_o && state_q != ST_DONE, pos_q < len, "position beyond line")

endmodule

// ===== src/sgb_datapath.sv =====
// Frame store, line buffer, tap MAC pipeline and result registers.
// Depends on sgb_pkg.
module sgb_datapath #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int AW  = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT),
  parameter int LD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT,
  parameter int LIW = $clog2(LD)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sgb_pkg::sgb_cmd_t  cmd_i,
  input  sgb_pkg::sgb_coef_t coef_i,
  input  logic [AW-1:0]      st_addr_i,
  input  logic [AW-1:0]      wb_addr_i,
  input  logic [LIW-1:0]     lb_addr_i,
  input  logic [31:0]        px_data_i,
  output logic               done_o,
  output logic               status_o,
  output logic [31:0]        px_out_o
);
  import sgb_pkg::*;

  logic [31:0] frame_mem [2**AW];
  logic [31:0] line_mem [LD];

  logic [31:0] rd_q, lb_q;
  logic [15:0] w_q;
  logic        vld1_q, first1_q, vld2_q, first2_q;
  logic [23:0] prod_q [4];
  logic [ACC_W-1:0] acc_q [4];
  logic        wb_v_q;
  logic [AW-1:0] wb_addr_q;
  logic        done_q, err_q, rdok_q;

  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0] wr_data, fin_px;
  logic [15:0] w_sel;

  always_comb begin
    case (cmd_i.wsel)
      WSEL_CENTER: w_sel = coef_i.center;
      WSEL_ONE:    w_sel = coef_i.one;
      WSEL_TWO:    w_sel = coef_i.two;
      WSEL_THREE:  w_sel = coef_i.three;
      WSEL_FOUR:   w_sel = coef_i.four;
      default:     w_sel = '0;
    endcase
  end

  assign wr_en   = cmd_i.px_wr || wb_v_q;
  assign wr_addr = cmd_i.px_wr ? st_addr_i : wb_addr_q;
  assign wr_data = cmd_i.px_wr ? px_data_i : lb_q;

  for (genvar c = 0; c < 4; c++) begin : g_fin
    assign fin_px[8*c +: 8] = round_sat(acc_q[c]);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) frame_mem[wr_addr] <= wr_data;
    rd_q <= frame_mem[st_addr_i];
    if (cmd_i.fin_en) line_mem[lb_addr_i] <= fin_px;
    lb_q <= line_mem[lb_addr_i];
    wb_addr_q <= wb_addr_i;
    w_q <= w_sel;
    for (int c = 0; c < 4; c++) begin
      prod_q[c] <= w_q * rd_q[8*c +: 8];
      if (vld2_q) acc_q[c] <= first2_q ? ACC_W'(prod_q[c]) : acc_q[c] + ACC_W'(prod_q[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q   <= 1'b0;
      first1_q <= 1'b0;
      vld2_q   <= 1'b0;
      first2_q <= 1'b0;
      wb_v_q   <= 1'b0;
      done_q   <= 1'b0;
      err_q    <= 1'b0;
      rdok_q   <= 1'b0;
    end else begin
      vld1_q   <= cmd_i.tap_en;
      first1_q <= cmd_i.tap_first;
      vld2_q   <= vld1_q;
      first2_q <= first1_q;
      wb_v_q   <= cmd_i.lb_rd;
      done_q   <= cmd_i.px_done || cmd_i.blur_done;
      err_q    <= cmd_i.px_err;
      rdok_q   <= cmd_i.px_rd;
    end
  end

  assign done_o   = done_q;
  assign status_o = err_q;
  assign px_out_o = rdok_q ? rd_q : 32'd0;

endmodule
